### hdl/ry420_pkg.sv
// ----------------------------------------------------------------------------
// ry420_pkg
// Shared widths, BT.601 limited-range coefficients and the saturation helper
// of the RGB with alpha to YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
package ry420_pkg;

   localparam int PIX_W              = 8;
   localparam int LINE_WIDTH_W       = 12;
   localparam int ALPHA_W            = 9;
   localparam int CSR_DATA_W         = 12;
   localparam int CSR_INDEX_W        = 1;
   localparam int MAX_WIDTH_DEFAULT  = 2048;
   localparam int LINE_WIDTH_RESET   = 640;
   localparam int ALPHA_RESET        = 256;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_LEVEL = 1'd1;

   // Color channel scaled by alpha: 8 x 9 bits.
   localparam int SCALED_W = PIX_W + ALPHA_W;
   // Accumulator: 17-bit signed coefficient times 17-bit scaled channel,
   // three terms plus offset, with sign.
   localparam int ACC_W    = 35;
   localparam int COEF_W   = 17;
   localparam int FRAC_W   = 24;

   localparam int CH_Y  = 0;
   localparam int CH_CB = 1;
   localparam int CH_CR = 2;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [ACC_W-1:0]  acc_type;

   // Rows are Y, Cb, Cr; columns weigh red, green and blue (scaled by 2^16).
   localparam coef_type COEF [3][3] = '{
      '{ 17'sd16829,  17'sd33039,  17'sd6416 },
      '{-17'sd9714,  -17'sd19071,  17'sd28784},
      '{ 17'sd28784, -17'sd24103, -17'sd4681 }
   };

   // Offset times 2^24 plus one half for rounding to nearest.
   localparam acc_type BIAS [3] = '{
      35'sd276824064,
      35'sd2155872256,
      35'sd2155872256
   };

   // Drop the fraction and clamp to 0..255.
   function automatic logic [PIX_W-1:0] sat_byte(input acc_type acc);
      logic [PIX_W-1:0] res;
      if (acc[ACC_W-1]) begin
         res = '0;
      end else if (|acc[ACC_W-2:FRAC_W+PIX_W]) begin
         res = '1;
      end else begin
         res = acc[FRAC_W+PIX_W-1:FRAC_W];
      end
      return res;
   endfunction

endpackage

### hdl/ry420_req_if.sv
// ----------------------------------------------------------------------------
// ry420_req_if
// Request channel: one RGB pixel with its frame start flag.
// ----------------------------------------------------------------------------
interface ry420_req_if;
   logic                          valid;
   logic                          ready;
   logic [ry420_pkg::PIX_W-1:0]   red;
   logic [ry420_pkg::PIX_W-1:0]   green;
   logic [ry420_pkg::PIX_W-1:0]   blue;
   logic                          frame_start;

   modport source (output valid, output red, output green, output blue,
                   output frame_start, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input frame_start, output ready);
endinterface

### hdl/ry420_rsp_if.sv
// ----------------------------------------------------------------------------
// ry420_rsp_if
// Response channel: luma of one pixel and the chroma of a completed block.
// ----------------------------------------------------------------------------
interface ry420_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ry420_pkg::PIX_W-1:0]   luma;
   logic                          chroma_valid;
   logic [ry420_pkg::PIX_W-1:0]   cb_avg;
   logic [ry420_pkg::PIX_W-1:0]   cr_avg;

   modport source (output valid, output luma, output chroma_valid,
                   output cb_avg, output cr_avg, input ready);
   modport sink   (input valid, input luma, input chroma_valid,
                   input cb_avg, input cr_avg, output ready);
endinterface

### hdl/rgb_alpha_to_yuv420_converter_top.sv
// ----------------------------------------------------------------------------
// rgb_alpha_to_yuv420_converter_top
// RGB888 pixels scaled by alpha, converted to BT.601 limited-range YUV 4:2:0.
// ----------------------------------------------------------------------------
// The block takes one pixel per request in raster order and returns one
// response per request: the luma of that pixel, and on the bottom-right pixel
// of every 2x2 block the averaged Cb and Cr of the block. The pixel is
// captured at the edge that accepts it and then passes through alpha
// scaling, coefficient multiply, sum with rounding and saturation, and the
// line store update with the response load. The block accepts the next
// request in the cycle after that load at the earliest, so it takes no new
// pixel before the previous one has passed every step. The line store is a
// single-port-per-side memory of MAX_WIDTH/2 entries of 18 bits that holds
// the Cb and Cr pair sums of the even row; it is read during the multiply step
// and written in the last step of the same request, and since only one
// request is in flight at a time no access can overlap another to the same
// entry. The next request is accepted as soon as the previous one has been
// handed to the response register, even while that response still waits to
// be taken; the last step waits only if an older response is still pending
// there, and then until that response is taken. The line width and alpha
// level are written through the csr_ port; the user must do so only while
// no request is in flight, as the block itself does not enforce it. The width
// has its low bit ignored and is held within 2 and MAX_WIDTH.
// ----------------------------------------------------------------------------
module rgb_alpha_to_yuv420_converter_top #(
   parameter int MAX_WIDTH = ry420_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   ry420_req_if.sink                            req,
   ry420_rsp_if.source                          rsp,
   input  logic                                 csr_wr_en,
   input  logic [ry420_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ry420_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // Store geometry follows from the largest line width.
   localparam int STORE_DEPTH = MAX_WIDTH / 2;
   localparam int SLOT_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int COL_W       = SLOT_W + 1;
   localparam int MAX_EVEN    = 2 * STORE_DEPTH;
   localparam int EW_W        = (COL_W + 1 > ry420_pkg::LINE_WIDTH_W) ?
                                COL_W + 1 : ry420_pkg::LINE_WIDTH_W;
   localparam int ENTRY_W     = 2 * (ry420_pkg::PIX_W + 1);
   localparam int PW          = ry420_pkg::PIX_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_MULT,
      ST_SUM,
      ST_WRITE
   } state_type;

   // Control state.
   state_type                              state_ff, state_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]                       col_ff, col_in;
   logic                                   odd_row_ff, odd_row_in;
   logic [ry420_pkg::LINE_WIDTH_W-1:0]     line_width_ff, line_width_in;
   logic [ry420_pkg::ALPHA_W-1:0]          alpha_level_ff, alpha_level_in;

   // Datapath registers.
   logic [PW-1:0]                          pix_ff [3];
   logic                                   fs_ff;
   logic [ry420_pkg::SCALED_W-1:0]         scaled_ff [3];
   ry420_pkg::acc_type                     prod_ff [3][3];
   logic [PW-1:0]                          ycc_ff [3];
   logic [PW-1:0]                          left_cb_ff, left_cr_ff;
   logic [ENTRY_W-1:0]                     mem_rdata_ff;
   logic [PW-1:0]                          luma_ff, cb_avg_ff, cr_avg_ff;
   logic                                   chroma_valid_ff;

   // Line store of even-row pair sums: Cr sum in the upper half.
   logic [ENTRY_W-1:0]                     pair_mem [STORE_DEPTH];

   logic                                   accept;
   logic                                   finish;
   logic [EW_W-1:0]                        lw_even;
   logic [EW_W-1:0]                        eff_width;
   logic [COL_W:0]                         col_inc;
   logic                                   odd_col;
   logic                                   block_done;
   logic                                   mem_we;
   logic [PW:0]                            pair_cb, pair_cr;
   logic [PW+1:0]                          quad_cb, quad_cr;
   logic [PW-1:0]                          cb_avg_in, cr_avg_in;
   ry420_pkg::acc_type                     acc [3];

   assign req.ready        = (state_ff == ST_IDLE);
   assign accept           = req.valid && req.ready;
   assign finish           = (state_ff == ST_WRITE) && (!rsp_valid_ff || rsp.ready);

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.luma         = luma_ff;
   assign rsp.chroma_valid = chroma_valid_ff;
   assign rsp.cb_avg       = cb_avg_ff;
   assign rsp.cr_avg       = cr_avg_ff;

   // Effective line width: even, at least 2, at most the store allows.
   always_comb begin
      lw_even    = EW_W'(line_width_ff);
      lw_even[0] = 1'b0;
      if (lw_even < EW_W'(2)) begin
         eff_width = EW_W'(2);
      end else if (lw_even > EW_W'(MAX_EVEN)) begin
         eff_width = EW_W'(MAX_EVEN);
      end else begin
         eff_width = lw_even;
      end
   end

   // Chroma of the 2x2 block: left and right of this row plus the stored
   // pair sums of the row above.
   always_comb begin
      odd_col    = col_ff[0];
      block_done = odd_col && odd_row_ff;
      mem_we     = finish && odd_col && !odd_row_ff;
      pair_cb    = (PW+1)'(left_cb_ff) + (PW+1)'(ycc_ff[ry420_pkg::CH_CB]);
      pair_cr    = (PW+1)'(left_cr_ff) + (PW+1)'(ycc_ff[ry420_pkg::CH_CR]);
      quad_cb    = (PW+2)'(mem_rdata_ff[PW:0]) + (PW+2)'(pair_cb);
      quad_cr    = (PW+2)'(mem_rdata_ff[ENTRY_W-1:PW+1]) + (PW+2)'(pair_cr);
      cb_avg_in  = block_done ? quad_cb[PW+1:2] : '0;
      cr_avg_in  = block_done ? quad_cr[PW+1:2] : '0;
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         acc[ch] = prod_ff[ch][0] + prod_ff[ch][1] + prod_ff[ch][2] +
                   ry420_pkg::BIAS[ch];
      end
   end

   // Next control state.
   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      col_in         = col_ff;
      odd_row_in     = odd_row_ff;
      line_width_in  = line_width_ff;
      alpha_level_in = alpha_level_ff;
      col_inc        = (COL_W+1)'(col_ff) + (COL_W+1)'(1);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            state_in = ST_MULT;
            if (fs_ff) begin
               col_in     = '0;
               odd_row_in = 1'b0;
            end
         end
         ST_MULT: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (finish) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (EW_W'(col_inc) >= eff_width) begin
                  col_in     = '0;
                  odd_row_in = !odd_row_ff;
               end else begin
                  col_in = col_inc[COL_W-1:0];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         unique case (csr_index)
            ry420_pkg::CSR_LINE_WIDTH: begin
               line_width_in = csr_wdata[ry420_pkg::LINE_WIDTH_W-1:0];
            end
            ry420_pkg::CSR_ALPHA_LEVEL: begin
               alpha_level_in = csr_wdata[ry420_pkg::ALPHA_W-1:0];
            end
            default: begin
               line_width_in = line_width_ff;
            end
         endcase
      end
   end

   // State machine with the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         col_ff         <= '0;
         odd_row_ff     <= 1'b0;
         line_width_ff  <= ry420_pkg::LINE_WIDTH_W'(ry420_pkg::LINE_WIDTH_RESET);
         alpha_level_ff <= ry420_pkg::ALPHA_W'(ry420_pkg::ALPHA_RESET);
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         col_ff         <= col_in;
         odd_row_ff     <= odd_row_in;
         line_width_ff  <= line_width_in;
         alpha_level_ff <= alpha_level_in;
         if (finish) begin
            luma_ff         <= ycc_ff[ry420_pkg::CH_Y];
            chroma_valid_ff <= block_done;
            cb_avg_ff       <= cb_avg_in;
            cr_avg_ff       <= cr_avg_in;
         end
      end
   end

   // Arithmetic pipeline steps, one per state.
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff[0] <= req.red;
         pix_ff[1] <= req.green;
         pix_ff[2] <= req.blue;
         fs_ff     <= req.frame_start;
      end
      if (state_ff == ST_SCALE) begin
         for (int k = 0; k < 3; k++) begin
            scaled_ff[k] <= ry420_pkg::SCALED_W'(pix_ff[k]) *
                            ry420_pkg::SCALED_W'(alpha_level_ff);
         end
      end
      if (state_ff == ST_MULT) begin
         for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 3; k++) begin
               prod_ff[ch][k] <= ry420_pkg::ACC_W'(ry420_pkg::COEF[ch][k]) *
                                 ry420_pkg::ACC_W'($signed({1'b0, scaled_ff[k]}));
            end
         end
      end
      if (state_ff == ST_SUM) begin
         for (int ch = 0; ch < 3; ch++) begin
            ycc_ff[ch] <= ry420_pkg::sat_byte(acc[ch]);
         end
      end
      if (finish && !odd_col) begin
         left_cb_ff <= ycc_ff[ry420_pkg::CH_CB];
         left_cr_ff <= ycc_ff[ry420_pkg::CH_CR];
      end
   end

   // Line store: read during the multiply step, written when the request ends.
   always_ff @(posedge clock) begin
      if (state_ff == ST_MULT) begin
         mem_rdata_ff <= pair_mem[col_ff[COL_W-1:1]];
      end
      if (mem_we) begin
         pair_mem[col_ff[COL_W-1:1]] <= {pair_cr, pair_cb};
      end
   end

   // A request that is accepted always starts the scaling step.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_SCALE)
      else $error("accepted request did not start processing");

   // Chroma is reported only on an odd column of an odd row.
   assert property (@(posedge clock) disable iff (reset)
      finish && block_done |-> odd_row_ff && col_ff[0] && !mem_we)
      else $error("chroma reported outside a block corner");

   // After a request the column either wraps or advances by one.
   assert property (@(posedge clock) disable iff (reset)
      finish |=> col_ff == '0 ||
                 (COL_W+1)'(col_ff) == (COL_W+1)'($past(col_ff)) + (COL_W+1)'(1))
      else $error("column did not advance by one");

   // A pending response leaves only through a handshake.
   assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(rsp.ready))
      else $error("response dropped without being taken");

   // The column never reaches the end of the store.
   assert property (@(posedge clock) disable iff (reset)
      finish |=> (COL_W+1)'(col_ff) < (COL_W+1)'(MAX_EVEN))
      else $error("column ran past the line store");

endmodule
